// File: rtl/core/sm83_alu_flags_top_macros.svh
// ----------------------------------------------------------------------------
// SM83 ALU assertion macros
// Shared concurrent assertion forms for the SM83 ALU pipeline.
// ----------------------------------------------------------------------------
`ifndef SM83_ALU_FLAGS_TOP_MACROS_SVH
`define SM83_ALU_FLAGS_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SM83_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define SM83_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/sm83alu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SM83 ALU package
// Word types, operation codes and constants shared by the pipeline stages.
// ----------------------------------------------------------------------------
package sm83alu_pkg;

  typedef enum logic [4:0] {
    OP_ADD   = 5'd0,
    OP_ADC   = 5'd1,
    OP_SUB   = 5'd2,
    OP_SBC   = 5'd3,
    OP_AND   = 5'd4,
    OP_XOR   = 5'd5,
    OP_OR    = 5'd6,
    OP_CP    = 5'd7,
    OP_INC   = 5'd8,
    OP_DEC   = 5'd9,
    OP_RLCA  = 5'd10,
    OP_RRCA  = 5'd11,
    OP_RLA   = 5'd12,
    OP_RRA   = 5'd13,
    OP_DAA   = 5'd14,
    OP_CPL   = 5'd15,
    OP_SCF   = 5'd16,
    OP_CCF   = 5'd17,
    OP_CB    = 5'd18,
    OP_ADDHL = 5'd19,
    OP_ADDSP = 5'd20,
    OP_NOP   = 5'd21
  } op_t;

  typedef enum logic [1:0] {
    CB_ROT = 2'd0,
    CB_BIT = 2'd1,
    CB_RES = 2'd2,
    CB_SET = 2'd3
  } cb_grp_t;

  typedef enum logic [2:0] {
    CB_RLC  = 3'd0,
    CB_RRC  = 3'd1,
    CB_RL   = 3'd2,
    CB_RR   = 3'd3,
    CB_SLA  = 3'd4,
    CB_SRA  = 3'd5,
    CB_SWAP = 3'd6,
    CB_SRL  = 3'd7
  } cb_kind_t;

  localparam int unsigned FLAG_Z = 3;
  localparam int unsigned FLAG_N = 2;
  localparam int unsigned FLAG_H = 1;
  localparam int unsigned FLAG_C = 0;

  localparam logic [3:0] NIBBLE_MAX  = 4'hF;
  localparam logic [3:0] BCD_DIGIT   = 4'h9;
  localparam logic [7:0] BCD_MAX     = 8'h99;
  localparam logic [7:0] DAA_LO_ADJ  = 8'h06;
  localparam logic [7:0] DAA_HI_ADJ  = 8'h60;
  localparam logic [7:0] BYTE_ONE    = 8'h01;
  localparam logic [7:0] BYTE_ZERO   = 8'h00;
  localparam logic [15:0] WIDE_ZERO  = 16'h0000;

  typedef struct packed {
    logic [4:0]  mode;
    logic [7:0]  acc;
    logic [7:0]  operand;
    logic [3:0]  flags_in;
    logic [7:0]  cb_code;
    logic [15:0] wide_base;
    logic [15:0] wide_addend;
  } in_word_t;

  typedef struct packed {
    logic [7:0]  result_byte;
    logic [15:0] result_wide;
    logic [3:0]  flags_out;
    logic        write_back;
  } out_word_t;

  // Decoded word leaving the first stage.
  typedef struct packed {
    op_t         op;
    logic [7:0]  acc;
    logic [7:0]  operand;
    logic [3:0]  flags;
    logic        carry_in;
    cb_grp_t     cb_grp;
    cb_kind_t    cb_kind;
    logic [7:0]  cb_mask;
    logic [15:0] wide_base;
    logic [15:0] wide_addend;
  } dec_word_t;

  // Raw results and flag terms leaving the second stage.
  typedef struct packed {
    op_t         op;
    cb_grp_t     cb_grp;
    logic [3:0]  flags;
    logic [7:0]  rb;
    logic [15:0] rw;
    logic [7:0]  zsrc;
    logic        h;
    logic        c;
  } exe_word_t;

endpackage

// File: rtl/core/sm83_alu_flags_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SM83 ALU and flag datapath
// Three-stage pipeline for the 8-bit CPU arithmetic, logic, rotate, CB-prefix
// and 16-bit add operations with Z/N/H/C flag generation.
// ----------------------------------------------------------------------------
// The block takes one word per cycle while the output is not stalled and passes
// each word through decode, execute and flag assembly, each stage holding one
// word behind its own register. The output stage is the result register, so
// a stalled result stalls the stages behind it one by one and item_ready only
// falls once all three stages hold a word and result_ready is low. Words come
// out in the order they went in. There is no state across words and no
// configuration.
module sm83_alu_flags_top (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   item_valid,
  output logic                   item_ready,
  input  sm83alu_pkg::in_word_t  item,
  output logic                   result_valid,
  input  logic                   result_ready,
  output sm83alu_pkg::out_word_t result
);

  `include "sm83_alu_flags_top_macros.svh"

  logic                   s1_valid;
  logic                   s1_ready;
  sm83alu_pkg::dec_word_t s1_word;
  logic                   s2_valid;
  logic                   s2_ready;
  sm83alu_pkg::exe_word_t s2_word;

  sm83alu_dec u_dec (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (item_valid),
    .in_ready  (item_ready),
    .in_word   (item),
    .valid     (s1_valid),
    .out_ready (s1_ready),
    .word      (s1_word)
  );

  sm83alu_exe u_exe (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s1_valid),
    .in_ready  (s1_ready),
    .in_word   (s1_word),
    .valid     (s2_valid),
    .out_ready (s2_ready),
    .word      (s2_word)
  );

  sm83alu_flg u_flg (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s2_valid),
    .in_ready  (s2_ready),
    .in_word   (s2_word),
    .valid     (result_valid),
    .out_ready (result_ready),
    .word      (result)
  );

  `SM83_ASSERT_NOW(a_full_stall, clk, rst,
                   s1_valid && s2_valid && result_valid && !result_ready,
                   !item_ready, "pipeline full and stalled but input still ready")

  `SM83_ASSERT_NEXT(a_s1_advance, clk, rst, s1_valid && s1_ready, s2_valid,
                    "decoded word lost between decode and execute")

  `SM83_ASSERT_NEXT(a_s2_advance, clk, rst, s2_valid && s2_ready, result_valid,
                    "executed word lost before the result register")

  `SM83_ASSERT_NOW(a_wide_byte, clk, rst,
                   result_valid && (result.result_wide != 16'h0000),
                   result.result_byte == 8'h00, "wide result with a nonzero byte result")

endmodule

// File: rtl/core/sm83alu_dec.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SM83 ALU decode stage
// Maps the mode to an operation, selects the carry input and decodes the
// CB-prefix byte into group, kind and bit mask.
// ----------------------------------------------------------------------------
module sm83alu_dec (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  sm83alu_pkg::in_word_t  in_word,
  output logic                   valid,
  input  logic                   out_ready,
  output sm83alu_pkg::dec_word_t word
);

  sm83alu_pkg::dec_word_t word_next;

  assign in_ready = !valid || out_ready;

  always_comb begin
    word_next.acc         = in_word.acc;
    word_next.operand     = in_word.operand;
    word_next.flags       = in_word.flags_in;
    word_next.wide_base   = in_word.wide_base;
    word_next.wide_addend = in_word.wide_addend;
    word_next.cb_grp      = sm83alu_pkg::cb_grp_t'(in_word.cb_code[7:6]);
    word_next.cb_kind     = sm83alu_pkg::cb_kind_t'(in_word.cb_code[5:3]);
    word_next.cb_mask     = sm83alu_pkg::BYTE_ONE << in_word.cb_code[5:3];
    if (in_word.mode > 5'(sm83alu_pkg::OP_ADDSP)) begin
      word_next.op = sm83alu_pkg::OP_NOP;
    end else begin
      word_next.op = sm83alu_pkg::op_t'(in_word.mode);
    end
    word_next.carry_in = in_word.flags_in[sm83alu_pkg::FLAG_C] &&
                         ((word_next.op == sm83alu_pkg::OP_ADC) ||
                          (word_next.op == sm83alu_pkg::OP_SBC));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      word <= word_next;
    end
  end

endmodule

// File: rtl/core/sm83alu_exe.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SM83 ALU execute stage
// Computes the byte and wide results with their half-carry and carry terms.
// ----------------------------------------------------------------------------
module sm83alu_exe (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  sm83alu_pkg::dec_word_t in_word,
  output logic                   valid,
  input  logic                   out_ready,
  output sm83alu_pkg::exe_word_t word
);

  sm83alu_pkg::exe_word_t word_next;

  assign in_ready = !valid || out_ready;

  always_comb begin
    logic [7:0]  a;
    logic [7:0]  v;
    logic        ci;
    logic        cin;
    logic        hin;
    logic        nin;
    logic [8:0]  sum9;
    logic [4:0]  sum_lo;
    logic [8:0]  dif9;
    logic [4:0]  dif_lo;
    logic [16:0] wsum;
    logic [12:0] wsum_lo;
    logic [15:0] spsum;
    logic [4:0]  sp_lo;
    logic [8:0]  sp_byte;
    logic        daa_lo;
    logic        daa_hi;
    logic [7:0]  daa_adj;

    a       = in_word.acc;
    v       = in_word.operand;
    ci      = in_word.carry_in;
    cin     = in_word.flags[sm83alu_pkg::FLAG_C];
    hin     = in_word.flags[sm83alu_pkg::FLAG_H];
    nin     = in_word.flags[sm83alu_pkg::FLAG_N];
    sum9    = {1'b0, a} + {1'b0, v} + {8'b0, ci};
    sum_lo  = {1'b0, a[3:0]} + {1'b0, v[3:0]} + {4'b0, ci};
    dif9    = {1'b0, a} - {1'b0, v} - {8'b0, ci};
    dif_lo  = {1'b0, a[3:0]} - {1'b0, v[3:0]} - {4'b0, ci};
    wsum    = {1'b0, in_word.wide_base} + {1'b0, in_word.wide_addend};
    wsum_lo = {1'b0, in_word.wide_base[11:0]} + {1'b0, in_word.wide_addend[11:0]};
    spsum   = in_word.wide_base + {{8{v[7]}}, v};
    sp_lo   = {1'b0, in_word.wide_base[3:0]} + {1'b0, v[3:0]};
    sp_byte = {1'b0, in_word.wide_base[7:0]} + {1'b0, v};
    if (nin) begin
      daa_lo = hin;
      daa_hi = cin;
    end else begin
      daa_lo = hin || (a[3:0] > sm83alu_pkg::BCD_DIGIT);
      daa_hi = cin || (a > sm83alu_pkg::BCD_MAX);
    end
    daa_adj = (daa_lo ? sm83alu_pkg::DAA_LO_ADJ : sm83alu_pkg::BYTE_ZERO) |
              (daa_hi ? sm83alu_pkg::DAA_HI_ADJ : sm83alu_pkg::BYTE_ZERO);

    word_next.op     = in_word.op;
    word_next.cb_grp = in_word.cb_grp;
    word_next.flags  = in_word.flags;
    word_next.rb     = a;
    word_next.rw     = sm83alu_pkg::WIDE_ZERO;
    word_next.zsrc   = a;
    word_next.h      = 1'b0;
    word_next.c      = 1'b0;

    case (in_word.op)
      sm83alu_pkg::OP_ADD, sm83alu_pkg::OP_ADC: begin
        word_next.rb = sum9[7:0];
        word_next.h  = sum_lo[4];
        word_next.c  = sum9[8];
      end
      sm83alu_pkg::OP_SUB, sm83alu_pkg::OP_SBC, sm83alu_pkg::OP_CP: begin
        word_next.rb = (in_word.op == sm83alu_pkg::OP_CP) ? a : dif9[7:0];
        word_next.h  = dif_lo[4];
        word_next.c  = dif9[8];
      end
      sm83alu_pkg::OP_AND: word_next.rb = a & v;
      sm83alu_pkg::OP_XOR: word_next.rb = a ^ v;
      sm83alu_pkg::OP_OR:  word_next.rb = a | v;
      sm83alu_pkg::OP_INC: begin
        word_next.rb = v + sm83alu_pkg::BYTE_ONE;
        word_next.h  = (v[3:0] == sm83alu_pkg::NIBBLE_MAX);
      end
      sm83alu_pkg::OP_DEC: begin
        word_next.rb = v - sm83alu_pkg::BYTE_ONE;
        word_next.h  = (v[3:0] == 4'h0);
      end
      sm83alu_pkg::OP_RLCA: begin
        word_next.rb = {a[6:0], a[7]};
        word_next.c  = a[7];
      end
      sm83alu_pkg::OP_RRCA: begin
        word_next.rb = {a[0], a[7:1]};
        word_next.c  = a[0];
      end
      sm83alu_pkg::OP_RLA: begin
        word_next.rb = {a[6:0], cin};
        word_next.c  = a[7];
      end
      sm83alu_pkg::OP_RRA: begin
        word_next.rb = {cin, a[7:1]};
        word_next.c  = a[0];
      end
      sm83alu_pkg::OP_DAA: begin
        word_next.rb = nin ? (a - daa_adj) : (a + daa_adj);
        word_next.c  = daa_hi;
      end
      sm83alu_pkg::OP_CPL: word_next.rb = ~a;
      sm83alu_pkg::OP_CB: begin
        case (in_word.cb_grp)
          sm83alu_pkg::CB_ROT: begin
            case (in_word.cb_kind)
              sm83alu_pkg::CB_RLC: begin
                word_next.rb = {v[6:0], v[7]};
                word_next.c  = v[7];
              end
              sm83alu_pkg::CB_RRC: begin
                word_next.rb = {v[0], v[7:1]};
                word_next.c  = v[0];
              end
              sm83alu_pkg::CB_RL: begin
                word_next.rb = {v[6:0], cin};
                word_next.c  = v[7];
              end
              sm83alu_pkg::CB_RR: begin
                word_next.rb = {cin, v[7:1]};
                word_next.c  = v[0];
              end
              sm83alu_pkg::CB_SLA: begin
                word_next.rb = {v[6:0], 1'b0};
                word_next.c  = v[7];
              end
              sm83alu_pkg::CB_SRA: begin
                word_next.rb = {v[7], v[7:1]};
                word_next.c  = v[0];
              end
              sm83alu_pkg::CB_SWAP: word_next.rb = {v[3:0], v[7:4]};
              default: begin
                word_next.rb = {1'b0, v[7:1]};
                word_next.c  = v[0];
              end
            endcase
          end
          sm83alu_pkg::CB_BIT: word_next.rb = v;
          sm83alu_pkg::CB_RES: word_next.rb = v & ~in_word.cb_mask;
          default:             word_next.rb = v | in_word.cb_mask;
        endcase
      end
      sm83alu_pkg::OP_ADDHL: begin
        word_next.rb = sm83alu_pkg::BYTE_ZERO;
        word_next.rw = wsum[15:0];
        word_next.h  = wsum_lo[12];
        word_next.c  = wsum[16];
      end
      sm83alu_pkg::OP_ADDSP: begin
        word_next.rb = sm83alu_pkg::BYTE_ZERO;
        word_next.rw = spsum;
        word_next.h  = sp_lo[4];
        word_next.c  = sp_byte[8];
      end
      default: word_next.rb = a;
    endcase

    if (in_word.op == sm83alu_pkg::OP_SUB || in_word.op == sm83alu_pkg::OP_SBC ||
        in_word.op == sm83alu_pkg::OP_CP) begin
      word_next.zsrc = dif9[7:0];
    end else if (in_word.op == sm83alu_pkg::OP_CB &&
                 in_word.cb_grp == sm83alu_pkg::CB_BIT) begin
      word_next.zsrc = v & in_word.cb_mask;
    end else begin
      word_next.zsrc = word_next.rb;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      word <= word_next;
    end
  end

endmodule

// File: rtl/core/sm83alu_flg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SM83 ALU flag stage
// Detects a zero result, assembles the new flags and holds the output word.
// ----------------------------------------------------------------------------
module sm83alu_flg (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  sm83alu_pkg::exe_word_t in_word,
  output logic                   valid,
  input  logic                   out_ready,
  output sm83alu_pkg::out_word_t word
);

  sm83alu_pkg::out_word_t word_next;

  assign in_ready = !valid || out_ready;

  always_comb begin
    logic z;
    logic zin;
    logic nin;
    logic cin;
    logic [3:0] fin;

    fin = in_word.flags;
    z   = (in_word.zsrc == sm83alu_pkg::BYTE_ZERO);
    zin = fin[sm83alu_pkg::FLAG_Z];
    nin = fin[sm83alu_pkg::FLAG_N];
    cin = fin[sm83alu_pkg::FLAG_C];

    word_next.result_byte = in_word.rb;
    word_next.result_wide = in_word.rw;
    word_next.write_back  = 1'b1;

    case (in_word.op)
      sm83alu_pkg::OP_ADD, sm83alu_pkg::OP_ADC:
        word_next.flags_out = {z, 1'b0, in_word.h, in_word.c};
      sm83alu_pkg::OP_SUB, sm83alu_pkg::OP_SBC:
        word_next.flags_out = {z, 1'b1, in_word.h, in_word.c};
      sm83alu_pkg::OP_CP: begin
        word_next.flags_out  = {z, 1'b1, in_word.h, in_word.c};
        word_next.write_back = 1'b0;
      end
      sm83alu_pkg::OP_AND:
        word_next.flags_out = {z, 1'b0, 1'b1, 1'b0};
      sm83alu_pkg::OP_XOR, sm83alu_pkg::OP_OR:
        word_next.flags_out = {z, 1'b0, 1'b0, 1'b0};
      sm83alu_pkg::OP_INC:
        word_next.flags_out = {z, 1'b0, in_word.h, cin};
      sm83alu_pkg::OP_DEC:
        word_next.flags_out = {z, 1'b1, in_word.h, cin};
      sm83alu_pkg::OP_RLCA, sm83alu_pkg::OP_RRCA, sm83alu_pkg::OP_RLA,
      sm83alu_pkg::OP_RRA:
        word_next.flags_out = {1'b0, 1'b0, 1'b0, in_word.c};
      sm83alu_pkg::OP_DAA:
        word_next.flags_out = {z, nin, 1'b0, in_word.c};
      sm83alu_pkg::OP_CPL:
        word_next.flags_out = {zin, 1'b1, 1'b1, cin};
      sm83alu_pkg::OP_SCF:
        word_next.flags_out = {zin, 1'b0, 1'b0, 1'b1};
      sm83alu_pkg::OP_CCF:
        word_next.flags_out = {zin, 1'b0, 1'b0, !cin};
      sm83alu_pkg::OP_CB: begin
        case (in_word.cb_grp)
          sm83alu_pkg::CB_ROT: word_next.flags_out = {z, 1'b0, 1'b0, in_word.c};
          sm83alu_pkg::CB_BIT: begin
            word_next.flags_out  = {z, 1'b0, 1'b1, cin};
            word_next.write_back = 1'b0;
          end
          default: word_next.flags_out = fin;
        endcase
      end
      sm83alu_pkg::OP_ADDHL:
        word_next.flags_out = {zin, 1'b0, in_word.h, in_word.c};
      sm83alu_pkg::OP_ADDSP:
        word_next.flags_out = {1'b0, 1'b0, in_word.h, in_word.c};
      default: begin
        word_next.flags_out  = fin;
        word_next.write_back = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      word <= word_next;
    end
  end

endmodule

// File: tb/sm83_alu_flags_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SM83 ALU and flag datapath testbench
// Drives operation words into the ALU pipeline through its valid/ready input
// and checks every result word, in order, against a table entry or a local
// model of the arithmetic, logic, rotate, decimal adjust, CB-prefix and 16-bit
// add operations. A short directed sweep covers the extremes and the odd flag
// rules, and random words follow under several sender and receiver stall
// patterns, including a long output hold-off that backs the pipeline up.
// ----------------------------------------------------------------------------
module sm83_alu_flags_top_tb;
  import sm83alu_pkg::*;

  typedef struct {
    in_word_t  stim;
    logic      known;
    out_word_t want;
  } dir_row_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      item_valid = 1'b0;
  logic      item_ready;
  in_word_t  item = '0;
  logic      result_valid;
  logic      result_ready = 1'b0;
  out_word_t result;

  out_word_t alu_expected[$];
  dir_row_t  directed_rows[$];
  int        mismatch_count = 0;
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;
  int        hold_left = 0;

  sm83_alu_flags_top DUT (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  always #5 clk = ~clk;

  function automatic out_word_t predict_alu(input in_word_t w);
    out_word_t  r;
    logic [8:0]  sum9;
    logic [4:0]  nib5;
    logic [16:0] sum17;
    logic [12:0] sum13;
    logic [7:0]  adj;
    logic [7:0]  v;
    logic [2:0]  y;
    logic        cy;
    logic        z_in;
    logic        n_in;
    logic        h_in;
    logic        c_in;
    v = w.operand;
    y = w.cb_code[5:3];
    z_in = w.flags_in[FLAG_Z];
    n_in = w.flags_in[FLAG_N];
    h_in = w.flags_in[FLAG_H];
    c_in = w.flags_in[FLAG_C];
    r = '0;
    r.flags_out = w.flags_in;
    r.write_back = 1'b1;
    case (op_t'(w.mode))
      OP_ADD, OP_ADC: begin
        cy = (op_t'(w.mode) == OP_ADC) && c_in;
        sum9 = {1'b0, w.acc} + {1'b0, v} + {8'b0, cy};
        nib5 = {1'b0, w.acc[3:0]} + {1'b0, v[3:0]} + {4'b0, cy};
        r.result_byte = sum9[7:0];
        r.flags_out = {r.result_byte == BYTE_ZERO, 1'b0, nib5[4], sum9[8]};
      end
      OP_SUB, OP_SBC, OP_CP: begin
        cy = (op_t'(w.mode) == OP_SBC) && c_in;
        adj = w.acc - v - {7'b0, cy};
        r.flags_out = {adj == BYTE_ZERO, 1'b1,
                       {1'b0, w.acc[3:0]} < {1'b0, v[3:0]} + {4'b0, cy},
                       {1'b0, w.acc} < {1'b0, v} + {8'b0, cy}};
        if (op_t'(w.mode) == OP_CP) begin
          r.result_byte = w.acc;
          r.write_back = 1'b0;
        end else begin
          r.result_byte = adj;
        end
      end
      OP_AND: begin
        r.result_byte = w.acc & v;
        r.flags_out = {r.result_byte == BYTE_ZERO, 1'b0, 1'b1, 1'b0};
      end
      OP_XOR: begin
        r.result_byte = w.acc ^ v;
        r.flags_out = {r.result_byte == BYTE_ZERO, 3'b000};
      end
      OP_OR: begin
        r.result_byte = w.acc | v;
        r.flags_out = {r.result_byte == BYTE_ZERO, 3'b000};
      end
      OP_INC: begin
        r.result_byte = v + BYTE_ONE;
        r.flags_out = {r.result_byte == BYTE_ZERO, 1'b0, v[3:0] == NIBBLE_MAX, c_in};
      end
      OP_DEC: begin
        r.result_byte = v - BYTE_ONE;
        r.flags_out = {r.result_byte == BYTE_ZERO, 1'b1, v[3:0] == 4'h0, c_in};
      end
      OP_RLCA: begin
        r.result_byte = {w.acc[6:0], w.acc[7]};
        r.flags_out = {3'b000, w.acc[7]};
      end
      OP_RRCA: begin
        r.result_byte = {w.acc[0], w.acc[7:1]};
        r.flags_out = {3'b000, w.acc[0]};
      end
      OP_RLA: begin
        r.result_byte = {w.acc[6:0], c_in};
        r.flags_out = {3'b000, w.acc[7]};
      end
      OP_RRA: begin
        r.result_byte = {c_in, w.acc[7:1]};
        r.flags_out = {3'b000, w.acc[0]};
      end
      OP_DAA: begin
        adj = BYTE_ZERO;
        cy = c_in;
        if (!n_in) begin
          if (h_in || w.acc[3:0] > BCD_DIGIT) adj = adj | DAA_LO_ADJ;
          if (cy || w.acc > BCD_MAX) begin
            adj = adj | DAA_HI_ADJ;
            cy = 1'b1;
          end
          r.result_byte = w.acc + adj;
        end else begin
          if (h_in) adj = adj | DAA_LO_ADJ;
          if (cy) adj = adj | DAA_HI_ADJ;
          r.result_byte = w.acc - adj;
        end
        r.flags_out = {r.result_byte == BYTE_ZERO, n_in, 1'b0, cy};
      end
      OP_CPL: begin
        r.result_byte = ~w.acc;
        r.flags_out = {z_in, 1'b1, 1'b1, c_in};
      end
      OP_SCF: begin
        r.result_byte = w.acc;
        r.flags_out = {z_in, 1'b0, 1'b0, 1'b1};
      end
      OP_CCF: begin
        r.result_byte = w.acc;
        r.flags_out = {z_in, 1'b0, 1'b0, ~c_in};
      end
      OP_CB: begin
        case (cb_grp_t'(w.cb_code[7:6]))
          CB_ROT: begin
            case (cb_kind_t'(y))
              CB_RLC: begin cy = v[7]; r.result_byte = {v[6:0], v[7]}; end
              CB_RRC: begin cy = v[0]; r.result_byte = {v[0], v[7:1]}; end
              CB_RL: begin cy = v[7]; r.result_byte = {v[6:0], c_in}; end
              CB_RR: begin cy = v[0]; r.result_byte = {c_in, v[7:1]}; end
              CB_SLA: begin cy = v[7]; r.result_byte = {v[6:0], 1'b0}; end
              CB_SRA: begin cy = v[0]; r.result_byte = {v[7], v[7:1]}; end
              CB_SWAP: begin cy = 1'b0; r.result_byte = {v[3:0], v[7:4]}; end
              default: begin cy = v[0]; r.result_byte = {1'b0, v[7:1]}; end
            endcase
            r.flags_out = {r.result_byte == BYTE_ZERO, 1'b0, 1'b0, cy};
          end
          CB_BIT: begin
            r.result_byte = v;
            r.write_back = 1'b0;
            r.flags_out = {~v[y], 1'b0, 1'b1, c_in};
          end
          CB_RES: r.result_byte = v & ~(BYTE_ONE << y);
          default: r.result_byte = v | (BYTE_ONE << y);
        endcase
      end
      OP_ADDHL: begin
        sum17 = {1'b0, w.wide_base} + {1'b0, w.wide_addend};
        sum13 = {1'b0, w.wide_base[11:0]} + {1'b0, w.wide_addend[11:0]};
        r.result_wide = sum17[15:0];
        r.flags_out = {z_in, 1'b0, sum13[12], sum17[16]};
      end
      OP_ADDSP: begin
        nib5 = {1'b0, w.wide_base[3:0]} + {1'b0, v[3:0]};
        sum9 = {1'b0, w.wide_base[7:0]} + {1'b0, v};
        r.result_wide = w.wide_base + {{8{v[7]}}, v};
        r.flags_out = {1'b0, 1'b0, nib5[4], sum9[8]};
      end
      default: begin
        r.result_byte = w.acc;
        r.write_back = 1'b0;
      end
    endcase
    return r;
  endfunction

  function automatic logic [7:0] rand_byte();
    logic [7:0] corners[8] = '{8'h00, 8'hFF, 8'h80, 8'h7F, 8'h0F, 8'hF0, 8'h99, 8'h01};
    if ($urandom_range(5) == 0) return corners[3'($urandom_range(7))];
    return 8'($urandom);
  endfunction

  function automatic logic [15:0] rand_wide();
    logic [15:0] corners[6] = '{16'h0000, 16'hFFFF, 16'h0FFF, 16'h00FF, 16'h8000, 16'hF000};
    if ($urandom_range(5) == 0) return corners[3'($urandom_range(5))];
    return 16'($urandom);
  endfunction

  function automatic in_word_t rand_item();
    in_word_t w;
    if ($urandom_range(99) < 6) w.mode = 5'($urandom_range(31, 21));
    else w.mode = 5'($urandom_range(20, 0));
    w.acc = rand_byte();
    w.operand = rand_byte();
    w.flags_in = 4'($urandom_range(15));
    w.cb_code = 8'($urandom);
    w.wide_base = rand_wide();
    w.wide_addend = rand_wide();
    return w;
  endfunction

  task automatic send_word(input in_word_t w, input out_word_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= w;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    alu_expected.push_back(want);
  endtask

  task automatic wait_drained();
    item_valid <= 1'b0;
    do @(posedge clk); while (alu_expected.size() != 0);
  endtask

  task automatic run_random(input int count, input int idle_pct, input int stall_pct);
    in_word_t w;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) begin
      w = rand_item();
      send_word(w, predict_alu(w));
    end
    wait_drained();
  endtask

  // The receiver counts down a requested hold-off on its own before going back
  // to random stalls.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        result_ready <= 1'b0;
        hold_left--;
      end else begin
        result_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin : result_check
    out_word_t want;
    if (!rst && result_valid && result_ready) begin
      if (alu_expected.size() == 0) begin
        $error("result word with no expectation: %h", result);
        mismatch_count++;
      end else begin
        want = alu_expected.pop_front();
        if (result.result_byte !== want.result_byte) begin
          $error("result_byte: expected %h, got %h", want.result_byte, result.result_byte);
          mismatch_count++;
        end
        if (result.result_wide !== want.result_wide) begin
          $error("result_wide: expected %h, got %h", want.result_wide, result.result_wide);
          mismatch_count++;
        end
        if (result.flags_out !== want.flags_out) begin
          $error("flags_out: expected %b, got %b", want.flags_out, result.flags_out);
          mismatch_count++;
        end
        if (result.write_back !== want.write_back) begin
          $error("write_back: expected %b, got %b", want.write_back, result.write_back);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    #(5_000_000);
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    in_word_t w;
    directed_rows.push_back('{in_word_t'{OP_ADD, 8'hFF, 8'h01, 4'h0, 8'h00, 16'h0000, 16'h0000},
                              1'b1, out_word_t'{8'h00, 16'h0000, 4'b1011, 1'b1}});
    directed_rows.push_back('{in_word_t'{OP_ADC, 8'hFF, 8'h00, 4'h1, 8'h00, 16'h0000, 16'h0000},
                              1'b1, out_word_t'{8'h00, 16'h0000, 4'b1011, 1'b1}});
    directed_rows.push_back('{in_word_t'{OP_SUB, 8'h00, 8'h01, 4'h0, 8'h00, 16'h0000, 16'h0000},
                              1'b1, out_word_t'{8'hFF, 16'h0000, 4'b0111, 1'b1}});
    directed_rows.push_back('{in_word_t'{OP_SBC, 8'h10, 8'h0F, 4'h1, 8'hFF, 16'hFFFF, 16'hFFFF},
                              1'b0, out_word_t'('0)});
    directed_rows.push_back('{in_word_t'{OP_AND, 8'h00, 8'hFF, 4'hF, 8'h00, 16'h0000, 16'h0000},
                              1'b1, out_word_t'{8'h00, 16'h0000, 4'b1010, 1'b1}});
    directed_rows.push_back('{in_word_t'{OP_XOR, 8'hFF, 8'hFF, 4'h0, 8'h00, 16'h0000, 16'h0000},
                              1'b1, out_word_t'{8'h00, 16'h0000, 4'b1000, 1'b1}});
    directed_rows.push_back('{in_word_t'{OP_OR, 8'h00, 8'h00, 4'h7, 8'h00, 16'h0000, 16'h0000},
                              1'b1, out_word_t'{8'h00, 16'h0000, 4'b1000, 1'b1}});
    directed_rows.push_back('{in_word_t'{OP_CP, 8'h42, 8'h42, 4'h0, 8'h00, 16'h0000, 16'h0000},
                              1'b1, out_word_t'{8'h42, 16'h0000, 4'b1100, 1'b0}});
    directed_rows.push_back('{in_word_t'{OP_INC, 8'h00, 8'hFF, 4'h1, 8'h00, 16'h0000, 16'h0000},
                              1'b1, out_word_t'{8'h00, 16'h0000, 4'b1011, 1'b1}});
    directed_rows.push_back('{in_word_t'{OP_DEC, 8'h00, 8'h00, 4'h0, 8'h00, 16'h0000, 16'h0000},
                              1'b1, out_word_t'{8'hFF, 16'h0000, 4'b0110, 1'b1}});
    directed_rows.push_back('{in_word_t'{OP_RLCA, 8'h80, 8'h00, 4'h8, 8'h00, 16'h0000, 16'h0000},
                              1'b1, out_word_t'{8'h01, 16'h0000, 4'b0001, 1'b1}});
    directed_rows.push_back('{in_word_t'{OP_RRCA, 8'h01, 8'h00, 4'hE, 8'h00, 16'h0000, 16'h0000},
                              1'b0, out_word_t'('0)});
    directed_rows.push_back('{in_word_t'{OP_RLA, 8'h00, 8'h00, 4'h9, 8'h00, 16'h0000, 16'h0000},
                              1'b0, out_word_t'('0)});
    directed_rows.push_back('{in_word_t'{OP_RRA, 8'hFF, 8'h00, 4'h8, 8'h00, 16'h0000, 16'h0000},
                              1'b0, out_word_t'('0)});
    directed_rows.push_back('{in_word_t'{OP_DAA, 8'h9A, 8'h00, 4'h0, 8'h00, 16'h0000, 16'h0000},
                              1'b0, out_word_t'('0)});
    directed_rows.push_back('{in_word_t'{OP_DAA, 8'h00, 8'h00, 4'h7, 8'h00, 16'h0000, 16'h0000},
                              1'b0, out_word_t'('0)});
    directed_rows.push_back('{in_word_t'{OP_CPL, 8'hFF, 8'h00, 4'h9, 8'h00, 16'h0000, 16'h0000},
                              1'b0, out_word_t'('0)});
    directed_rows.push_back('{in_word_t'{OP_SCF, 8'h5A, 8'h00, 4'hE, 8'h00, 16'h0000, 16'h0000},
                              1'b0, out_word_t'('0)});
    directed_rows.push_back('{in_word_t'{OP_CCF, 8'hA5, 8'h00, 4'h9, 8'h00, 16'h0000, 16'h0000},
                              1'b0, out_word_t'('0)});
    directed_rows.push_back('{in_word_t'{OP_CB, 8'h00, 8'hF0, 4'hF, 8'h30, 16'h0000, 16'h0000},
                              1'b0, out_word_t'('0)});
    directed_rows.push_back('{in_word_t'{OP_CB, 8'h00, 8'h01, 4'h0, 8'h38, 16'h0000, 16'h0000},
                              1'b0, out_word_t'('0)});
    directed_rows.push_back('{in_word_t'{OP_CB, 8'h00, 8'h00, 4'h1, 8'h78, 16'h0000, 16'h0000},
                              1'b0, out_word_t'('0)});
    directed_rows.push_back('{in_word_t'{OP_CB, 8'h00, 8'hFF, 4'h5, 8'h80, 16'h0000, 16'h0000},
                              1'b0, out_word_t'('0)});
    directed_rows.push_back('{in_word_t'{OP_CB, 8'h00, 8'h00, 4'hA, 8'hFF, 16'h0000, 16'h0000},
                              1'b0, out_word_t'('0)});
    directed_rows.push_back('{in_word_t'{OP_ADDHL, 8'h00, 8'h00, 4'h8, 8'h00, 16'hFFFF, 16'h0001},
                              1'b1, out_word_t'{8'h00, 16'h0000, 4'b1011, 1'b1}});
    directed_rows.push_back('{in_word_t'{OP_ADDSP, 8'h00, 8'h80, 4'hF, 8'h00, 16'h00FF, 16'h0000},
                              1'b0, out_word_t'('0)});
    directed_rows.push_back('{in_word_t'{5'd31, 8'h5A, 8'hFF, 4'hF, 8'hFF, 16'hFFFF, 16'hFFFF},
                              1'b1, out_word_t'{8'h5A, 16'h0000, 4'b1111, 1'b0}});

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      send_word(directed_rows[i].stim,
                directed_rows[i].known ? directed_rows[i].want
                                       : predict_alu(directed_rows[i].stim));
    end
    wait_drained();

    run_random(420, 0, 0);

    // Hold the output off long enough for the pipeline to fill and push back
    // on the input while words keep coming.
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_left = 80;
    repeat (30) begin
      w = rand_item();
      send_word(w, predict_alu(w));
    end
    wait_drained();

    run_random(420, 71, 0);
    run_random(420, 0, 71);
    run_random(420, 27, 27);

    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl/core
rtl/core/sm83alu_pkg.sv
rtl/core/sm83alu_dec.sv
rtl/core/sm83alu_exe.sv
rtl/core/sm83alu_flg.sv
rtl/core/sm83_alu_flags_top.sv
tb/sm83_alu_flags_top_tb.sv
